### hw/rtl/lpm_pkg.sv
// shared types, constants and helpers for the ipv4 longest prefix route lookup
package lpm_pkg;

  // table geometry
  localparam int ROUTES  = 16;
  localparam int PORTS   = 4;
  localparam int IDX_W   = (ROUTES > 1) ? $clog2(ROUTES) : 1;

  // fixed field widths
  localparam int ADDR_W  = 32;
  localparam int INDEX_W = 4;
  localparam int PORT_W  = 2;

  // request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [PORT_W-1:0] port;
  } route_t;

  typedef struct packed {
    logic               hit;
    logic [PORT_W-1:0]  port;
    logic [ADDR_W-1:0]  mask;
    logic [INDEX_W-1:0] index;
  } result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } scan_stat_t;

  // index field to table slot
  function automatic logic [IDX_W-1:0] slot_of_index(input logic [INDEX_W-1:0] e);
    logic [IDX_W+INDEX_W-1:0] t;
    t = {{IDX_W{1'b0}}, e};
    return t[IDX_W-1:0];
  endfunction

  // table slot to index field, low bits only
  function automatic logic [INDEX_W-1:0] index_of_slot(input logic [IDX_W-1:0] s);
    logic [IDX_W+INDEX_W-1:0] t;
    t = {{INDEX_W{1'b0}}, s};
    return t[INDEX_W-1:0];
  endfunction

  // clamp an egress port to the last existing port
  function automatic logic [PORT_W-1:0] sat_port(input logic [PORT_W-1:0] p);
    logic [PORT_W-1:0] r;
    if (32'(p) >= 32'(PORTS)) begin
      r = PORT_W'(PORTS - 1);
    end else begin
      r = p;
    end
    return r;
  endfunction

endpackage

### hw/rtl/lpm_route_ram.sv
// route table memory: dest, mask and port in a synchronous ram, valid bits in flops
module lpm_route_ram (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [lpm_pkg::IDX_W-1:0] wr_addr,
  input  logic                     wr_live,
  input  lpm_pkg::route_t          wr_entry,
  input  logic [lpm_pkg::IDX_W-1:0] rd_addr,
  output lpm_pkg::route_t          rd_entry,
  output logic                     rd_live
);

  lpm_pkg::route_t            mem [lpm_pkg::ROUTES];
  logic [lpm_pkg::ROUTES-1:0] live;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (wr_en) begin
        live[wr_addr] <= wr_live;
      end
      rd_live <= live[rd_addr];
    end
  end

endmodule

### hw/rtl/lpm_scan.sv
// scan engine: walks the route table one slot a cycle and keeps the best match
module lpm_scan (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lpm_pkg::ADDR_W-1:0] addr,
  input  logic                      take,
  output lpm_pkg::scan_stat_t       stat,
  output lpm_pkg::result_t          res,
  output logic [lpm_pkg::IDX_W-1:0]  rd_addr,
  input  lpm_pkg::route_t           rd_entry,
  input  logic                      rd_live
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [lpm_pkg::IDX_W-1:0]  rd_idx;
  logic [lpm_pkg::IDX_W-1:0]  cmp_slot;
  logic                      issued;
  logic [lpm_pkg::ADDR_W-1:0] key;
  logic                      found;
  logic [lpm_pkg::ADDR_W-1:0] best_mask;
  logic [lpm_pkg::PORT_W-1:0] best_port;
  logic [lpm_pkg::IDX_W-1:0]  best_slot;
  logic                      last_issue;
  logic                      take_now;

  assign last_issue = (rd_idx == lpm_pkg::IDX_W'(lpm_pkg::ROUTES - 1));
  assign rd_addr    = rd_idx;

  // one 32-bit match test and one 32-bit mask compare per cycle
  assign take_now = issued && rd_live
                    && (((rd_entry.dest ^ key) & rd_entry.mask) == '0)
                    && (!found || (best_mask <= rd_entry.mask));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      rd_idx    <= '0;
      found     <= 1'b0;
      best_mask <= '0;
      best_port <= '0;
      best_slot <= '0;
    end else begin
      state  <= state_next;
      issued <= (state == S_SCAN);
      if (state == S_IDLE && start) begin
        rd_idx    <= '0;
        found     <= 1'b0;
        best_mask <= '0;
        best_port <= '0;
        best_slot <= '0;
      end else begin
        if (state == S_SCAN && !last_issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (take_now) begin
          found     <= 1'b1;
          best_mask <= rd_entry.mask;
          best_port <= rd_entry.port;
          best_slot <= cmp_slot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      key <= addr;
    end
    cmp_slot <= rd_idx;
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

  assign res.hit   = found;
  assign res.port  = best_port;
  assign res.mask  = best_mask;
  assign res.index = lpm_pkg::index_of_slot(best_slot);

  // a lookup only starts from idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("lookup started while scan busy");

  // returning read data always follows an issue cycle
  a_issue_order: assert property (@(posedge clk) disable iff (rst)
    issued |-> $past(state) == S_SCAN)
    else $error("read data without an issued read");

  // the counter stops on the last slot for the drain cycle
  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> last_issue && issued)
    else $error("drain without last slot in flight");

  // no read is in flight once the result is held
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> !issued)
    else $error("read in flight while result held");

  // no match means an all zero result
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    !found |-> best_mask == '0 && best_port == '0 && best_slot == '0)
    else $error("stale best match without a hit");

endmodule

### hw/rtl/ipv4_longest_prefix_route_lookup.sv
// top level of the ipv4 longest prefix route lookup with its output register
//
// ipv4 longest prefix route lookup over a table of lpm_pkg::ROUTES routes
// (16 here). each input word is either a route write (req_type 0) or an
// address lookup (req_type 1), and each gives exactly one result word. a
// write loads one slot and returns an all zero result; slots at or above
// the table size are ignored, and ports at or above lpm_pkg::PORTS are
// clamped to the last port. a lookup reads the route memory one slot per
// cycle through its single read port, compares the last slot read in a
// drain state, and then loads the result into the output register when
// that register has room. the winner is the valid route with the
// numerically largest mask whose masked destination equals the masked
// address, the higher slot winning a tie; a zero mask route is the default
// route. the block takes one word at a time: in_stall stays high while a
// lookup scans the table, and a new word can be taken while a finished
// result still waits in the output register only once that register is
// free or being drained. writes reach the memory only while no scan runs,
// so reads and writes never collide. the valid bits are all cleared
// together by reset; no clearing pass.
module ipv4_longest_prefix_route_lookup (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [lpm_pkg::INDEX_W-1:0] entry_index,
  input  logic                        entry_valid,
  input  logic [lpm_pkg::ADDR_W-1:0]  entry_dest,
  input  logic [lpm_pkg::ADDR_W-1:0]  entry_mask,
  input  logic [lpm_pkg::PORT_W-1:0]  entry_port,
  input  logic [lpm_pkg::ADDR_W-1:0]  lookup_addr,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic [lpm_pkg::PORT_W-1:0]  egress_port,
  output logic [lpm_pkg::ADDR_W-1:0]  matched_mask,
  output logic [lpm_pkg::INDEX_W-1:0] matched_index
);

  logic                      out_free;
  logic                      in_acc;
  logic                      wr_en;
  logic                      start;
  logic                      take;
  lpm_pkg::route_t           wr_entry;
  lpm_pkg::route_t           rd_entry;
  logic                      rd_live;
  logic [lpm_pkg::IDX_W-1:0]  rd_addr;
  lpm_pkg::scan_stat_t       stat;
  lpm_pkg::result_t          res;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  // take a new word only with the scanner idle and room for its result
  assign in_stall = !(stat.idle && out_free);
  assign in_acc   = in_valid && !in_stall;

  // writes outside the table are dropped
  assign wr_en = in_acc && (req_type == lpm_pkg::REQ_WRITE)
                 && (32'(entry_index) < 32'(lpm_pkg::ROUTES));
  assign start = in_acc && (req_type == lpm_pkg::REQ_LOOKUP);

  // finished lookup moves into the output register when it has room
  assign take = stat.done && out_free;

  assign wr_entry.dest = entry_dest;
  assign wr_entry.mask = entry_mask;
  assign wr_entry.port = lpm_pkg::sat_port(entry_port);

  lpm_route_ram u_ram (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (lpm_pkg::slot_of_index(entry_index)),
    .wr_live  (entry_valid),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_live  (rd_live)
  );

  lpm_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .addr     (lookup_addr),
    .take     (take),
    .stat     (stat),
    .res      (res),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_live  (rd_live)
  );

  // output register; a write word and a scan result never load together
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && (req_type == lpm_pkg::REQ_WRITE)) begin
      out_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (req_type == lpm_pkg::REQ_WRITE)) begin
      hit           <= 1'b0;
      egress_port   <= '0;
      matched_mask  <= '0;
      matched_index <= '0;
    end else if (take) begin
      hit           <= res.hit;
      egress_port   <= res.port;
      matched_mask  <= res.mask;
      matched_index <= res.index;
    end
  end

endmodule
